@@ rtl/pulse_baseline_peak_onset_macros.svh @@
// ----------------------------------------------------------------------------
// Pulse baseline, peak and onset finder: assertion macros
// Shared concurrent assertion forms, clocked on aclk and reset by aresetn.
// ----------------------------------------------------------------------------
`ifndef PULSE_BASELINE_PEAK_ONSET_MACROS_SVH
`define PULSE_BASELINE_PEAK_ONSET_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PBPO_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after a reset cycle.
`define PBPO_ASSERT_AFTER_RESET(label, cons, msg) \
    label: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pbpo_pkg.sv @@
// ----------------------------------------------------------------------------
// Pulse baseline, peak and onset finder: package
// Field widths, status codes, defaults and the types passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package pbpo_pkg;

    localparam int SAMPLE_W             = 16;
    localparam int TIME_W               = 10;
    localparam int BASE_W               = 20;
    localparam int AMP_W                = 21;
    localparam int STATUS_W             = 2;
    localparam int RUN_W                = 4;
    localparam int RUN_MAX              = 15;
    localparam int BASELINE_LEN_DEFAULT = 96;
    localparam int MAX_LEN_DEFAULT      = 1024;

    localparam logic [RUN_W-1:0] ONSET_RUN_RESET = 4'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] peak_value;
        logic [TIME_W-1:0]          peak_time;
        logic [TIME_W-1:0]          onset_time;
        logic                       onset_found;
        logic [STATUS_W-1:0]        status;
    } meas_t;

    typedef struct packed {
        logic signed [BASE_W-1:0]   baseline_q4;
        logic signed [SAMPLE_W-1:0] peak_value;
        logic [TIME_W-1:0]          peak_time;
        logic [TIME_W-1:0]          onset_time;
        logic                       onset_found;
        logic signed [AMP_W-1:0]    amplitude_q4;
        logic [STATUS_W-1:0]        status;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/pbpo_track.sv @@
// ----------------------------------------------------------------------------
// Pulse baseline, peak and onset finder: running waveform state
// Updates the baseline sum (first BASELINE_LEN samples), minimum and onset
// search up to MAX_LEN samples; snapshots the results at the last sample.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpo_track
    import pbpo_pkg::*;
#(
    parameter int BASELINE_LEN = BASELINE_LEN_DEFAULT,
    parameter int MAX_LEN      = MAX_LEN_DEFAULT
) (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    input  wire logic                                            cfg_we,
    input  wire logic [RUN_W-1:0]                                cfg_wdata,
    input  wire logic                                            in_accept,
    input  wire logic signed [SAMPLE_W-1:0]                      in_sample,
    input  wire logic                                            in_last,
    input  wire logic                                            advance,
    output logic                                                 snap_valid,
    output logic signed [SAMPLE_W+$clog2(BASELINE_LEN)-1:0]      snap_sum,
    output meas_t                                                snap_meas
);

    localparam int IDX_W = $clog2(MAX_LEN + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(BASELINE_LEN);

    logic [RUN_W-1:0]           onset_run_reg;
    logic [IDX_W-1:0]           index_reg, index_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic [TIME_W-1:0]          min_idx_reg, min_idx_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [RUN_W-1:0]           fall_reg, fall_next;
    logic                       seen_reg, seen_next;
    logic [TIME_W-1:0]          onset_idx_reg, onset_idx_next;
    logic                       overlong_reg, overlong_next;
    logic                       snap_valid_reg;
    logic signed [SUM_W-1:0]    snap_sum_reg;
    meas_t                      snap_meas_reg, snap_meas_next;
    logic [RUN_W-1:0]           need;

    always_comb begin
        need           = (onset_run_reg == '0) ? RUN_W'(1) : onset_run_reg;
        index_next     = index_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        min_idx_next   = min_idx_reg;
        prev_next      = prev_reg;
        fall_next      = fall_reg;
        seen_next      = seen_reg;
        onset_idx_next = onset_idx_reg;
        overlong_next  = overlong_reg;

        if (index_reg >= IDX_W'(MAX_LEN)) begin
            overlong_next = 1'b1;
        end else begin
            if (32'(index_reg) < BASELINE_LEN) begin
                sum_next = sum_reg + SUM_W'(in_sample);
            end
            if (index_reg == '0) begin
                min_next     = in_sample;
                min_idx_next = '0;
            end else begin
                if (in_sample < min_reg) begin
                    min_next     = in_sample;
                    min_idx_next = TIME_W'(index_reg);
                end
                if (!seen_reg) begin
                    if (in_sample < prev_reg) begin
                        fall_next = (fall_reg == RUN_W'(RUN_MAX)) ? fall_reg
                                                                   : fall_reg + 1'b1;
                    end else begin
                        fall_next = '0;
                    end
                    if (fall_next == need) begin
                        seen_next      = 1'b1;
                        onset_idx_next = TIME_W'(index_reg) - TIME_W'(need - 1'b1);
                    end
                end
            end
            prev_next  = in_sample;
            index_next = index_reg + 1'b1;
        end

        snap_meas_next.peak_value  = min_next;
        snap_meas_next.peak_time   = min_idx_next;
        snap_meas_next.onset_time  = seen_next ? onset_idx_next : '0;
        snap_meas_next.onset_found = seen_next;
        if (overlong_next) begin
            snap_meas_next.status = STATUS_LONG;
        end else if (32'(index_next) < BASELINE_LEN) begin
            snap_meas_next.status = STATUS_SHORT;
        end else begin
            snap_meas_next.status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            onset_run_reg  <= ONSET_RUN_RESET;
            index_reg      <= '0;
            sum_reg        <= '0;
            min_reg        <= '0;
            min_idx_reg    <= '0;
            prev_reg       <= '0;
            fall_reg       <= '0;
            seen_reg       <= 1'b0;
            onset_idx_reg  <= '0;
            overlong_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                onset_run_reg <= cfg_wdata;
            end
            if (in_accept) begin
                if (in_last) begin
                    index_reg     <= '0;
                    sum_reg       <= '0;
                    min_reg       <= '0;
                    min_idx_reg   <= '0;
                    prev_reg      <= '0;
                    fall_reg      <= '0;
                    seen_reg      <= 1'b0;
                    onset_idx_reg <= '0;
                    overlong_reg  <= 1'b0;
                end else begin
                    index_reg     <= index_next;
                    sum_reg       <= sum_next;
                    min_reg       <= min_next;
                    min_idx_reg   <= min_idx_next;
                    prev_reg      <= prev_next;
                    fall_reg      <= fall_next;
                    seen_reg      <= seen_next;
                    onset_idx_reg <= onset_idx_next;
                    overlong_reg  <= overlong_next;
                end
            end
            if (advance) begin
                snap_valid_reg <= in_accept && in_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_accept && in_last) begin
            snap_sum_reg  <= sum_next;
            snap_meas_reg <= snap_meas_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_sum   = snap_sum_reg;
    assign snap_meas  = snap_meas_reg;

endmodule

`default_nettype wire

@@ rtl/pbpo_finish.sv @@
// ----------------------------------------------------------------------------
// Pulse baseline, peak and onset finder: result pipeline
// Divides sixteen times the baseline sum by the window length, rounding
// towards minus infinity, by a reciprocal multiply with one correction step,
// then forms the amplitude.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpo_finish
    import pbpo_pkg::*;
#(
    parameter int BASELINE_LEN = BASELINE_LEN_DEFAULT
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       advance,
    input  wire logic                                       in_valid,
    input  wire logic signed [SAMPLE_W+$clog2(BASELINE_LEN)-1:0] in_sum,
    input  wire meas_t                                      in_meas,
    output logic                                            out_valid,
    output res_t                                            out_res
);

    localparam int SUM_W = SAMPLE_W + $clog2(BASELINE_LEN);
    localparam int NUM_W = SUM_W + 4;
    localparam int DW    = $clog2(BASELINE_LEN + 1);

    localparam logic [NUM_W:0]   RECIP = (NUM_W+1)'((64'd1 << NUM_W) / BASELINE_LEN);
    localparam logic [DW-1:0]    DIV   = DW'(BASELINE_LEN);
    localparam logic [NUM_W-1:0] DIV_N = NUM_W'(BASELINE_LEN);

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                    neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [NUM_W-1:0]        abs1_reg, abs2_reg, abs3_reg;
    logic [NUM_W-1:0]        qe2_reg, qe3_reg, qe4_reg;
    logic [NUM_W-1:0]        prod3_reg, rem4_reg;
    logic signed [BASE_W-1:0] base5_reg;
    meas_t                   meas1_reg, meas2_reg, meas3_reg, meas4_reg, meas5_reg;

    logic [NUM_W-1:0]        num_u;
    logic [NUM_W-1:0]        abs1_next;
    logic [2*NUM_W:0]        full2;
    logic [NUM_W+DW-1:0]     full3;
    logic                    ge, exact;
    logic [BASE_W-1:0]       q5;
    logic [BASE_W-1:0]       base5_next;
    logic signed [BASE_W-1:0] peak_q4;

    always_comb begin
        num_u      = {in_sum, 4'b0000};
        abs1_next  = num_u[NUM_W-1] ? (~num_u + 1'b1) : num_u;
        full2      = {{(NUM_W+1){1'b0}}, abs1_reg} * {{NUM_W{1'b0}}, RECIP};
        full3      = {{DW{1'b0}}, qe2_reg} * {{NUM_W{1'b0}}, DIV};
        ge         = (rem4_reg >= DIV_N);
        exact      = (rem4_reg == '0) || (rem4_reg == DIV_N);
        q5         = qe4_reg[BASE_W-1:0] + BASE_W'(ge);
        base5_next = neg4_reg ? (~q5 + BASE_W'(exact)) : q5;
        peak_q4    = {meas5_reg.peak_value, 4'b0000};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            neg1_reg  <= in_sum[SUM_W-1];
            abs1_reg  <= abs1_next;
            meas1_reg <= in_meas;

            neg2_reg  <= neg1_reg;
            abs2_reg  <= abs1_reg;
            qe2_reg   <= full2[2*NUM_W-1:NUM_W];
            meas2_reg <= meas1_reg;

            neg3_reg  <= neg2_reg;
            abs3_reg  <= abs2_reg;
            qe3_reg   <= qe2_reg;
            prod3_reg <= full3[NUM_W-1:0];
            meas3_reg <= meas2_reg;

            neg4_reg  <= neg3_reg;
            qe4_reg   <= qe3_reg;
            rem4_reg  <= abs3_reg - prod3_reg;
            meas4_reg <= meas3_reg;

            base5_reg <= base5_next;
            meas5_reg <= meas4_reg;
        end
    end

    always_comb begin
        out_res.baseline_q4  = base5_reg;
        out_res.peak_value   = meas5_reg.peak_value;
        out_res.peak_time    = meas5_reg.peak_time;
        out_res.onset_time   = meas5_reg.onset_time;
        out_res.onset_found  = meas5_reg.onset_found;
        out_res.amplitude_q4 = AMP_W'(peak_q4) - AMP_W'(base5_reg);
        out_res.status       = meas5_reg.status;
    end

    assign out_valid = v5_reg;

endmodule

`default_nettype wire

@@ rtl/pbpo_skid.sv @@
// ----------------------------------------------------------------------------
// Pulse baseline, peak and onset finder: output register and skid stage
// Holds the result being offered and catches one more while it is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpo_skid
    import pbpo_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    input  wire res_t in_data,
    output logic      in_ready,
    output logic      out_valid,
    output res_t      out_data,
    input  wire logic out_ready
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/pulse_baseline_peak_onset.sv @@
// ----------------------------------------------------------------------------
// Pulse baseline, peak and onset finder: top level
// Throughput is one sample per cycle while s_tready is high. A waveform's
// result, once its last sample is taken, passes the snapshot register, five
// result pipeline stages and the output register before m_tvalid offers it.
// A synchronous active-low reset clears all waveform state and onset_run to 5.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pulse_baseline_peak_onset_macros.svh"

module pulse_baseline_peak_onset
    import pbpo_pkg::*;
#(
    parameter int BASELINE_LEN = BASELINE_LEN_DEFAULT,
    parameter int MAX_LEN      = MAX_LEN_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [RUN_W-1:0] cfg_wdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,   // sample [15:0]
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // baseline_q4 [19:0], peak_value [35:20], peak_time [45:36],
    // onset_time [55:46], amplitude_q4 [76:56], zero [79:77]
    output logic [79:0]           m_tdata,
    output logic [2:0]            m_tuser    // onset_found [0], status [2:1]
);

    localparam int SUM_W = SAMPLE_W + $clog2(BASELINE_LEN);

    logic                    accept;
    logic                    advance;
    logic                    snap_valid;
    logic signed [SUM_W-1:0] snap_sum;
    meas_t                   snap_meas;
    logic                    fin_valid;
    res_t                    fin_res;
    res_t                    out_res;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = advance;

    pbpo_track #(
        .BASELINE_LEN (BASELINE_LEN),
        .MAX_LEN      (MAX_LEN)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_accept  (accept),
        .in_sample  (s_tdata),
        .in_last    (s_tlast),
        .advance    (advance),
        .snap_valid (snap_valid),
        .snap_sum   (snap_sum),
        .snap_meas  (snap_meas)
    );

    pbpo_finish #(
        .BASELINE_LEN (BASELINE_LEN)
    ) u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (snap_valid),
        .in_sum    (snap_sum),
        .in_meas   (snap_meas),
        .out_valid (fin_valid),
        .out_res   (fin_res)
    );

    pbpo_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fin_valid),
        .in_data   (fin_res),
        .in_ready  (advance),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'b000, out_res.amplitude_q4, out_res.onset_time,
                      out_res.peak_time, out_res.peak_value, out_res.baseline_q4};
    assign m_tuser = {out_res.status, out_res.onset_found};

    `PBPO_ASSERT_AFTER_RESET(a_ready_after_reset, s_tready, "input not ready after reset")
    `PBPO_ASSERT_HOLD(a_skid_needs_output, !s_tready, m_tvalid, "skid full with no result offered")
    `PBPO_ASSERT_HOLD(a_snap_from_last, snap_valid && $past(s_tready), $past(s_tvalid && s_tlast), "snapshot without a last sample")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Pulse baseline, peak and onset finder: testbench
// Streams waveforms into the block, predicts baseline, peak, onset, amplitude
// and status of each one, and checks every result transfer field by field.
// Covers short, single-sample and over-long waveforms, fixed and random
// onset_run settings and random idling and back-pressure on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pbpo_pkg::*;

    localparam int BL          = BASELINE_LEN_DEFAULT;
    localparam int ML          = MAX_LEN_DEFAULT;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;

    typedef logic [SAMPLE_W-1:0] wave_t[$];

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [RUN_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [15:0]      s_tdata;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [79:0]      m_tdata;
    logic [2:0]       m_tuser;

    pulse_baseline_peak_onset u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Running waveform measurement and the results still to be seen.
    logic [RUN_W-1:0]           onset_run_cfg = ONSET_RUN_RESET;
    logic [10:0]                wf_count;
    logic signed [22:0]         wf_sum;
    logic signed [SAMPLE_W-1:0] wf_min;
    logic [TIME_W-1:0]          wf_min_at;
    logic signed [SAMPLE_W-1:0] wf_prev;
    logic [RUN_W-1:0]           wf_falls;
    logic                       wf_onset_seen;
    logic [TIME_W-1:0]          wf_onset_at;
    logic                       wf_overlong;
    res_t                       pulse_q[$];

    bit tx_idle;
    bit rx_idle;
    int hold_off_len = 0;
    int mismatches   = 0;
    int cycle_count  = 0;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void forget_waveform();
        wf_count      = '0;
        wf_sum        = '0;
        wf_min        = '0;
        wf_min_at     = '0;
        wf_prev       = '0;
        wf_falls      = '0;
        wf_onset_seen = 1'b0;
        wf_onset_at   = '0;
        wf_overlong   = 1'b0;
    endfunction

    function automatic void measure_sample(input logic [SAMPLE_W-1:0] raw, input logic lst);
        logic signed [SAMPLE_W-1:0] s;
        logic [RUN_W-1:0]           need;
        longint                     num;
        longint                     base;
        longint                     amp;
        res_t                       r;
        s    = raw;
        need = (onset_run_cfg == '0) ? RUN_W'(1) : onset_run_cfg;
        if (wf_count >= ML) begin
            wf_overlong = 1'b1;
        end else begin
            if (wf_count < BL) wf_sum = wf_sum + s;
            if (wf_count == '0) begin
                wf_min    = s;
                wf_min_at = '0;
            end else begin
                if (s < wf_min) begin
                    wf_min    = s;
                    wf_min_at = wf_count[TIME_W-1:0];
                end
                if (!wf_onset_seen) begin
                    if (s < wf_prev) begin
                        if (wf_falls < RUN_MAX) wf_falls = wf_falls + 1'b1;
                    end else begin
                        wf_falls = '0;
                    end
                    if (wf_falls == need) begin
                        wf_onset_seen = 1'b1;
                        wf_onset_at   = wf_count[TIME_W-1:0] - TIME_W'(need - 1'b1);
                    end
                end
            end
            wf_prev  = s;
            wf_count = wf_count + 1'b1;
        end
        if (lst) begin
            num  = longint'(wf_sum) * 16;
            base = num / BL;
            if ((num % BL) != 0 && num < 0) base = base - 1;
            amp  = longint'(wf_min) * 16 - base;
            r.baseline_q4  = BASE_W'(base);
            r.peak_value   = wf_min;
            r.peak_time    = wf_min_at;
            r.onset_time   = wf_onset_seen ? wf_onset_at : '0;
            r.onset_found  = wf_onset_seen;
            r.amplitude_q4 = AMP_W'(amp);
            if (wf_overlong) r.status = STATUS_LONG;
            else if (wf_count < BL) r.status = STATUS_SHORT;
            else r.status = STATUS_OK;
            pulse_q.push_back(r);
            forget_waveform();
        end
    endfunction

    function automatic int idle_len(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 99) return $urandom_range(4, 20);
        return $urandom_range(30, 100);
    endfunction

    function automatic wave_t make_pulse(input int len);
        wave_t w;
        int    lvl;
        int    depth;
        int    fall;
        int    start;
        int    noise;
        int    v;
        if ($urandom_range(0, 9) == 0) lvl = int'($urandom_range(0, 65535)) - 32768;
        else lvl = int'($urandom_range(0, 4000)) - 2000;
        depth = $urandom_range(0, 40000);
        fall  = $urandom_range(1, 20);
        noise = $urandom_range(0, 6);
        if (len > BL) start = $urandom_range(BL / 2, len - 1);
        else start = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            if (i < start) begin
                v = lvl;
            end else if (i < start + fall) begin
                v = lvl - depth * (i - start + 1) / fall;
            end else begin
                v = lvl - depth + depth * (i - start - fall) / (4 * fall + 8);
                if (v > lvl) v = lvl;
            end
            v = v + int'($urandom_range(0, 2 * noise)) - noise;
            if (v > 32767) v = 32767;
            else if (v < -32768) v = -32768;
            w.push_back(SAMPLE_W'(v));
        end
        return w;
    endfunction

    function automatic wave_t make_noise(input int len);
        wave_t w;
        for (int i = 0; i < len; i++) w.push_back(SAMPLE_W'($urandom));
        return w;
    endfunction

    task automatic send_samples(input wave_t w);
        int gap;
        for (int i = 0; i < w.size(); i++) begin
            gap = idle_len(tx_idle);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 16'($urandom);
                s_tlast  <= 1'($urandom);
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= w[i];
            s_tlast  <= (i == w.size() - 1);
            do @(posedge aclk); while (!s_tready);
            measure_sample(w[i], i == w.size() - 1);
        end
    endtask

    task automatic pause_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pulse_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_onset_run(input logic [RUN_W-1:0] value);
        pause_input();
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        onset_run_cfg = value;
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s: expected %h, got %h", field, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_results
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pulse_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result transfer with none expected: tdata %h, tuser %h",
                             m_tdata, m_tuser);
            end else begin
                want = pulse_q.pop_front();
                compare_field("baseline_q4", want.baseline_q4[BASE_W-1:0], m_tdata[19:0]);
                compare_field("peak_value", want.peak_value[SAMPLE_W-1:0], m_tdata[35:20]);
                compare_field("peak_time", want.peak_time, m_tdata[45:36]);
                compare_field("onset_time", want.onset_time, m_tdata[55:46]);
                compare_field("amplitude_q4", want.amplitude_q4[AMP_W-1:0], m_tdata[76:56]);
                compare_field("padding", '0, m_tdata[79:77]);
                compare_field("onset_found", want.onset_found, m_tuser[0]);
                compare_field("status", want.status, m_tuser[2:1]);
            end
        end
    end

    initial begin : receiver
        int n;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_len > 0) begin
                n = hold_off_len;
                hold_off_len = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                n = idle_len(rx_idle);
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    task automatic test_single_sample();
        send_samples('{16'h8000});
    endtask

    task automatic test_short_with_zero_run();
        set_onset_run(4'd0);
        send_samples('{16'h7FFF, 16'h8000, 16'h8000, 16'h0064});
    endtask

    task automatic test_onset_stops_after_found();
        set_onset_run(4'd3);
        send_samples('{16'h000A, 16'h0009, 16'h0008, 16'h0007, 16'h0014, 16'hFFFD});
    endtask

    task automatic test_longest_run();
        wave_t w;
        set_onset_run(4'd15);
        for (int i = 0; i < 16; i++) w.push_back(SAMPLE_W'(100 - i));
        send_samples(w);
    endtask

    task automatic test_random_pulses();
        int               sent;
        int               count;
        int               pick;
        logic [RUN_W-1:0] run;
        wave_t            w;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: run = 4'd1;
                1: run = 4'd15;
                2: run = RUN_W'($urandom_range(2, 14));
                3: run = RUN_W'($urandom_range(0, 15));
                default: run = ONSET_RUN_RESET;
            endcase
            set_onset_run(run);
            sent  = 0;
            count = 0;
            while (sent < 100 || count < 2) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
                pick    = $urandom_range(0, 9);
                if (pick < 5) w = make_pulse($urandom_range(1, 30));
                else if (pick < 9) w = make_pulse($urandom_range(BL, BL + 20));
                else w = make_noise($urandom_range(1, 100));
                send_samples(w);
                sent  = sent + w.size();
                count = count + 1;
            end
        end
    endtask

    task automatic test_overlong();
        wave_t w;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        w = make_pulse($urandom_range(ML + 1, ML + 8));
        for (int i = 0; i < ML - 1; i++) if (w[i] == 16'h8000) w[i] = 16'h8001;
        w[ML - 1] = 16'h8000;
        w[ML]     = 16'h8000;
        send_samples(w);
    endtask

    task automatic test_output_backpressure();
        pause_input();
        tx_idle      = 1'b0;
        hold_off_len = 300;
        while (hold_off_len != 0) @(posedge aclk);
        for (int i = 0; i < 30; i++) send_samples(make_pulse($urandom_range(1, 3)));
        pause_input();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        forget_waveform();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_sample();
        test_short_with_zero_run();
        test_onset_stops_after_found();
        test_longest_run();
        test_random_pulses();
        test_overlong();
        test_output_backpressure();

        pause_input();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pulse_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
